### hdl/buffer_pool_frame_manager_assert.svh
// -----------------------------------------------------------------------------
// Buffer pool frame manager assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// -----------------------------------------------------------------------------
`ifndef BUFFER_POOL_FRAME_MANAGER_ASSERT_SVH
`define BUFFER_POOL_FRAME_MANAGER_ASSERT_SVH

// Same-cycle implication
`define BPFM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpfm assertion failed");

// Next-cycle implication
`define BPFM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpfm assertion failed");

`endif

### hdl/bpfm_pkg.sv
// -----------------------------------------------------------------------------
// Buffer pool frame manager package
// Sizes, command and status codes, and the controller/datapath structs.
// -----------------------------------------------------------------------------
package bpfm_pkg;

    localparam int FRAMES   = 16;
    localparam int PIN_BITS = 16;
    localparam int FRAME_W  = $clog2(FRAMES);
    localparam int CNT_W    = $clog2(FRAMES + 1);
    localparam int PAGE_W   = 32;

    localparam logic [PAGE_W-1:0] NO_PAGE = '1;

    // Command codes
    localparam logic [2:0] CMD_FETCH     = 3'd0;
    localparam logic [2:0] CMD_UNPIN     = 3'd1;
    localparam logic [2:0] CMD_FLUSH     = 3'd2;
    localparam logic [2:0] CMD_NEW       = 3'd3;
    localparam logic [2:0] CMD_DELETE    = 3'd4;
    localparam logic [2:0] CMD_FLUSH_ALL = 3'd5;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_RES   = 3'd1;
    localparam logic [2:0] ST_IN_USE    = 3'd2;
    localparam logic [2:0] ST_NO_FRAME  = 3'd3;
    localparam logic [2:0] ST_INVALID   = 3'd4;
    localparam logic [2:0] ST_PIN_SAT   = 3'd5;

    typedef struct packed {
        logic capture;
        logic look;
        logic exec;
        logic scan_step;
    } t_dp_cmd;

    typedef struct packed {
        logic             flush_all;
        logic             scan_emit;
        logic             scan_done;
        logic [CNT_W-1:0] free_cnt;
        logic [CNT_W-1:0] lru_cnt;
    } t_dp_stat;

    typedef struct packed {
        logic [2:0]               status;
        logic [3:0]               frame;
        logic                     write_back;
        logic signed [PAGE_W-1:0] write_back_page;
        logic                     read_in;
        logic                     clear_frame;
        logic                     deallocate;
        logic                     last;
    } t_result;

    // Frame index as the 4-bit result field
    function automatic logic [3:0] frame_field(input logic [FRAME_W-1:0] f);
        logic [FRAME_W+3:0] t;
        t = {4'b0000, f};
        return t[3:0];
    endfunction

endpackage

### hdl/bpfm_if.sv
// -----------------------------------------------------------------------------
// Buffer pool frame manager channels
// Command and result channels with valid/ready handshake.
// -----------------------------------------------------------------------------
interface bpfm_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         command;
    logic signed [31:0] page_id;
    logic               mark_dirty;

    modport source (output valid, command, page_id, mark_dirty, input ready);
    modport sink   (input valid, command, page_id, mark_dirty, output ready);
endinterface

interface bpfm_res_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [3:0]         frame;
    logic               write_back;
    logic signed [31:0] write_back_page;
    logic               read_in;
    logic               clear_frame;
    logic               deallocate;
    logic               last;

    modport source (output valid, status, frame, write_back, write_back_page, read_in,
                    clear_frame, deallocate, last, input ready);
    modport sink   (input valid, status, frame, write_back, write_back_page, read_in,
                    clear_frame, deallocate, last, output ready);
endinterface

### hdl/buffer_pool_frame_manager.sv
// -----------------------------------------------------------------------------
// Buffer pool frame manager
// Page-to-frame mapping with pin counts, dirty marks, free FIFO and LRU victims.
// -----------------------------------------------------------------------------
//  channel   dir  payload
//  i_cmd     in   command, page_id, mark_dirty
//  o_res     out  status, frame, write_back, write_back_page, read_in,
//                 clear_frame, deallocate, last
//
// A command runs through capture, frame search and execute; flush all runs
// through capture and frame search, then scans frames up to the last resident one.
// One command is in work at a time; i_cmd.ready is high only when idle.
// The result register holds a transaction until o_res.ready; the block stalls
// execution meanwhile. Synchronous active-low reset; no clearing pass.
module buffer_pool_frame_manager (
    input  logic               i_clk,
    input  logic               i_rst_n,
    bpfm_cmd_if.sink           i_cmd,
    bpfm_res_if.source         o_res
);

`include "buffer_pool_frame_manager_assert.svh"

    bpfm_pkg::t_dp_cmd  dp_cmd;
    bpfm_pkg::t_dp_stat dp_stat;
    bpfm_pkg::t_result  result;

    bpfm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (i_cmd.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    bpfm_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .i_command    (i_cmd.command),
        .i_page_id    (i_cmd.page_id),
        .i_mark_dirty (i_cmd.mark_dirty),
        .o_stat       (dp_stat),
        .o_result     (result)
    );

    assign o_res.status          = result.status;
    assign o_res.frame           = result.frame;
    assign o_res.write_back      = result.write_back;
    assign o_res.write_back_page = result.write_back_page;
    assign o_res.read_in         = result.read_in;
    assign o_res.clear_frame     = result.clear_frame;
    assign o_res.deallocate      = result.deallocate;
    assign o_res.last            = result.last;

    // Checks
    `BPFM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_cmd.valid && i_cmd.ready, !i_cmd.ready)
    `BPFM_ASSERT_NOW(a_lists_bounded, i_clk, i_rst_n, 1'b1, ({1'b0, dp_stat.free_cnt} + {1'b0, dp_stat.lru_cnt}) <= (bpfm_pkg::CNT_W + 1)'(bpfm_pkg::FRAMES))
    `BPFM_ASSERT_NOW(a_fail_no_frame, i_clk, i_rst_n, o_res.valid && o_res.status != bpfm_pkg::ST_OK, o_res.frame == 4'd0 && !o_res.write_back)
    `BPFM_ASSERT_NOW(a_wb_page_zero, i_clk, i_rst_n, o_res.valid && !o_res.write_back, o_res.write_back_page == 32'sd0)

endmodule

### hdl/bpfm_dp.sv
// -----------------------------------------------------------------------------
// Buffer pool frame manager datapath
// Frame table, free FIFO, LRU list, page lookup and result register.
// -----------------------------------------------------------------------------
module bpfm_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bpfm_pkg::t_dp_cmd                 i_cmd,
    input  logic [2:0]                        i_command,
    input  logic [bpfm_pkg::PAGE_W-1:0]       i_page_id,
    input  logic                              i_mark_dirty,
    output bpfm_pkg::t_dp_stat                o_stat,
    output bpfm_pkg::t_result                 o_result
);

    localparam int FR = bpfm_pkg::FRAMES;
    localparam int FW = bpfm_pkg::FRAME_W;
    localparam int CW = bpfm_pkg::CNT_W;
    localparam int PW = bpfm_pkg::PAGE_W;
    localparam int PB = bpfm_pkg::PIN_BITS;

    // Captured transaction
    logic [2:0]    r_cmd;
    logic [PW-1:0] r_pid;
    logic          r_md;

    // Lookup result
    logic          r_hit;
    logic [FW-1:0] r_hit_f;

    // Frame table and lists
    logic [PW-1:0] r_page  [FR];
    logic [PB-1:0] r_pin   [FR];
    logic          r_dirty [FR];
    logic [FW-1:0] r_free  [FR];
    logic [CW-1:0] r_free_cnt;
    logic [FW-1:0] r_lru   [FR];
    logic [CW-1:0] r_lru_cnt;

    logic [PW-1:0] n_page  [FR];
    logic [PB-1:0] n_pin   [FR];
    logic          n_dirty [FR];
    logic [FW-1:0] n_free  [FR];
    logic [CW-1:0] n_free_cnt;
    logic [FW-1:0] n_lru   [FR];
    logic [CW-1:0] n_lru_cnt;

    // Flush-all scan
    logic [FW-1:0] r_scan;
    logic          r_any;
    logic [FW-1:0] n_scan;
    logic          n_any;

    bpfm_pkg::t_result r_res;
    bpfm_pkg::t_result n_res;

    logic          look_hit;
    logic [FW-1:0] look_f;
    logic [FW-1:0] lru_rm  [FR];
    logic [FW-1:0] lru_pop [FR];
    logic [FW-1:0] free_pop[FR];
    logic          rm_found;
    logic          have_free;
    logic          have_lru;
    logic [FW-1:0] vic;
    logic          vic_wb;
    logic          here_res;
    logic          above_res;
    logic          emit;
    logic          done;

    // Search frames for the captured page id
    always_comb begin
        look_hit = 1'b0;
        look_f   = '0;
        for (int i = FR - 1; i >= 0; i--) begin
            if (r_pid != bpfm_pkg::NO_PAGE && r_page[i] == r_pid) begin
                look_hit = 1'b1;
                look_f   = FW'(i);
            end
        end
    end

    // Compact the LRU list without the hit frame; shifted lists for head pops
    always_comb begin
        logic seen;
        seen     = 1'b0;
        rm_found = 1'b0;
        for (int i = 0; i < FR; i++) begin
            if (CW'(i) < r_lru_cnt && r_lru[i] == r_hit_f) begin
                seen     = 1'b1;
                rm_found = 1'b1;
            end
            if (i < FR - 1) begin
                lru_rm[i]   = seen ? r_lru[i+1] : r_lru[i];
                lru_pop[i]  = r_lru[i+1];
                free_pop[i] = r_free[i+1];
            end else begin
                lru_rm[i]   = r_lru[i];
                lru_pop[i]  = r_lru[i];
                free_pop[i] = r_free[i];
            end
        end
    end

    // Pick a frame for a page not yet resident
    always_comb begin
        have_free = (r_free_cnt != '0);
        have_lru  = (r_lru_cnt != '0);
        vic       = have_free ? r_free[0] : r_lru[0];
        vic_wb    = r_dirty[vic] && (r_page[vic] != bpfm_pkg::NO_PAGE);
    end

    // Scan position checks
    always_comb begin
        here_res  = (r_page[r_scan] != bpfm_pkg::NO_PAGE);
        above_res = 1'b0;
        for (int i = 0; i < FR; i++) begin
            if (FW'(i) > r_scan && r_page[i] != bpfm_pkg::NO_PAGE) begin
                above_res = 1'b1;
            end
        end
        done = (here_res && !above_res) || (r_scan == FW'(FR - 1) && !r_any);
        emit = here_res || done;
    end

    // Next state of table, lists and result
    always_comb begin
        n_page     = r_page;
        n_pin      = r_pin;
        n_dirty    = r_dirty;
        n_free     = r_free;
        n_free_cnt = r_free_cnt;
        n_lru      = r_lru;
        n_lru_cnt  = r_lru_cnt;
        n_scan     = r_scan;
        n_any      = r_any;
        n_res      = r_res;

        if (i_cmd.capture) begin
            n_scan = '0;
            n_any  = 1'b0;
        end

        if (i_cmd.exec) begin
            n_res        = '0;
            n_res.last   = 1'b1;
            case (r_cmd)
                bpfm_pkg::CMD_FETCH, bpfm_pkg::CMD_NEW: begin
                    if (r_pid == bpfm_pkg::NO_PAGE) begin
                        n_res.status = bpfm_pkg::ST_INVALID;
                    end else if (r_hit && r_cmd == bpfm_pkg::CMD_NEW) begin
                        n_res.status = bpfm_pkg::ST_IN_USE;
                    end else if (r_hit) begin
                        if (r_pin[r_hit_f] == '1) begin
                            n_res.status = bpfm_pkg::ST_PIN_SAT;
                        end else begin
                            n_pin[r_hit_f] = r_pin[r_hit_f] + PB'(1);
                            n_lru          = lru_rm;
                            if (rm_found) begin
                                n_lru_cnt = r_lru_cnt - CW'(1);
                            end
                            n_res.frame = bpfm_pkg::frame_field(r_hit_f);
                        end
                    end else if (!have_free && !have_lru) begin
                        n_res.status = bpfm_pkg::ST_NO_FRAME;
                    end else begin
                        if (have_free) begin
                            n_free     = free_pop;
                            n_free_cnt = r_free_cnt - CW'(1);
                        end else begin
                            n_lru     = lru_pop;
                            n_lru_cnt = r_lru_cnt - CW'(1);
                        end
                        n_page[vic]           = r_pid;
                        n_dirty[vic]          = 1'b0;
                        n_pin[vic]            = PB'(1);
                        n_res.frame           = bpfm_pkg::frame_field(vic);
                        n_res.write_back      = vic_wb;
                        n_res.write_back_page = vic_wb ? r_page[vic] : '0;
                        n_res.read_in         = (r_cmd == bpfm_pkg::CMD_FETCH);
                        n_res.clear_frame     = 1'b1;
                    end
                end
                bpfm_pkg::CMD_UNPIN: begin
                    if (!r_hit) begin
                        n_res.status = bpfm_pkg::ST_NOT_RES;
                    end else begin
                        if (r_md) begin
                            n_dirty[r_hit_f] = 1'b1;
                        end
                        if (r_pin[r_hit_f] == '0) begin
                            n_res.status = bpfm_pkg::ST_IN_USE;
                        end else begin
                            n_pin[r_hit_f] = r_pin[r_hit_f] - PB'(1);
                            // a pinned frame is never on the list; append at tail
                            if (r_pin[r_hit_f] == PB'(1) && r_lru_cnt < CW'(FR)) begin
                                n_lru[r_lru_cnt[FW-1:0]] = r_hit_f;
                                n_lru_cnt                = r_lru_cnt + CW'(1);
                            end
                            n_res.frame = bpfm_pkg::frame_field(r_hit_f);
                        end
                    end
                end
                bpfm_pkg::CMD_FLUSH: begin
                    if (r_pid == bpfm_pkg::NO_PAGE) begin
                        n_res.status = bpfm_pkg::ST_INVALID;
                    end else if (!r_hit) begin
                        n_res.status = bpfm_pkg::ST_NOT_RES;
                    end else begin
                        n_dirty[r_hit_f]      = 1'b0;
                        n_res.frame           = bpfm_pkg::frame_field(r_hit_f);
                        n_res.write_back      = 1'b1;
                        n_res.write_back_page = r_pid;
                    end
                end
                bpfm_pkg::CMD_DELETE: begin
                    if (!r_hit) begin
                        n_res.status = bpfm_pkg::ST_OK;
                    end else if (r_pin[r_hit_f] != '0) begin
                        n_res.status = bpfm_pkg::ST_IN_USE;
                    end else begin
                        n_page[r_hit_f]  = bpfm_pkg::NO_PAGE;
                        n_dirty[r_hit_f] = 1'b0;
                        n_lru            = lru_rm;
                        if (rm_found) begin
                            n_lru_cnt = r_lru_cnt - CW'(1);
                        end
                        if (r_free_cnt < CW'(FR)) begin
                            n_free[r_free_cnt[FW-1:0]] = r_hit_f;
                            n_free_cnt                 = r_free_cnt + CW'(1);
                        end
                        n_res.frame       = bpfm_pkg::frame_field(r_hit_f);
                        n_res.clear_frame = 1'b1;
                        n_res.deallocate  = 1'b1;
                    end
                end
                default: begin
                    n_res.status = bpfm_pkg::ST_INVALID;
                end
            endcase
        end

        // One frame per step of flush all
        if (i_cmd.scan_step) begin
            if (emit) begin
                n_res      = '0;
                n_res.last = done;
                if (here_res) begin
                    n_dirty[r_scan]       = 1'b0;
                    n_res.frame           = bpfm_pkg::frame_field(r_scan);
                    n_res.write_back      = 1'b1;
                    n_res.write_back_page = r_page[r_scan];
                end
            end
            n_any  = r_any || here_res;
            n_scan = r_scan + FW'(1);
        end
    end

    // Frame table and list registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FR; i++) begin
                r_page[i]  <= bpfm_pkg::NO_PAGE;
                r_pin[i]   <= '0;
                r_dirty[i] <= 1'b0;
                r_free[i]  <= FW'(i);
            end
            r_free_cnt <= CW'(FR);
            r_lru_cnt  <= '0;
            r_scan     <= '0;
            r_any      <= 1'b0;
            r_hit      <= 1'b0;
        end else begin
            r_page     <= n_page;
            r_pin      <= n_pin;
            r_dirty    <= n_dirty;
            r_free     <= n_free;
            r_free_cnt <= n_free_cnt;
            r_lru_cnt  <= n_lru_cnt;
            r_scan     <= n_scan;
            r_any      <= n_any;
            if (i_cmd.look) begin
                r_hit <= look_hit;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_lru <= n_lru;
        r_res <= n_res;
        if (i_cmd.look) begin
            r_hit_f <= look_f;
        end
        if (i_cmd.capture) begin
            r_cmd <= i_command;
            r_pid <= i_page_id;
            r_md  <= i_mark_dirty;
        end
    end

    always_comb begin
        o_stat.flush_all = (r_cmd == bpfm_pkg::CMD_FLUSH_ALL);
        o_stat.scan_emit = emit;
        o_stat.scan_done = done;
        o_stat.free_cnt  = r_free_cnt;
        o_stat.lru_cnt   = r_lru_cnt;
    end

    assign o_result = r_res;

endmodule

### hdl/bpfm_ctrl.sv
// -----------------------------------------------------------------------------
// Buffer pool frame manager controller
// Sequences capture, lookup, execute and flush-all scan; owns result valid.
// -----------------------------------------------------------------------------
module bpfm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  bpfm_pkg::t_dp_stat  i_stat,
    output bpfm_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_EXEC,
        S_SCAN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    always_comb begin
        out_free    = !r_out_valid || i_out_ready;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = i_stat.flush_all ? S_SCAN : S_EXEC;
            end
            // Wait for the result register, then run the command
            S_EXEC: begin
                if (out_free) begin
                    o_cmd.exec  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            // Advance one frame per cycle while the result register is free
            S_SCAN: begin
                if (out_free) begin
                    o_cmd.scan_step = 1'b1;
                    if (i_stat.scan_emit) begin
                        n_out_valid = 1'b1;
                    end
                    if (i_stat.scan_done) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Buffer pool frame manager testbench
// Drives commands into the frame manager and checks every result transaction
// against a cycle-free predictor of frames, pins, dirty marks, free FIFO and
// LRU order. Covers directed corner cases and stacked pins, followed by
// random traffic with idle bursts on both channels and a long result stall.
// -----------------------------------------------------------------------------
module tb_top;

    localparam int PIN_MAX   = (1 << bpfm_pkg::PIN_BITS) - 1;
    localparam int WDOG_MAX  = 2000;
    localparam int LONG_HOLD = 300;
    localparam int PIN_DEPTH = 6;

    logic i_clk;
    logic i_rst_n;

    bpfm_cmd_if cmd_if ();
    bpfm_res_if res_if ();

    buffer_pool_frame_manager DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if.sink),
        .o_res   (res_if.source)
    );

    // Predictor state
    logic [bpfm_pkg::PAGE_W-1:0] page_of[bpfm_pkg::FRAMES];
    int                          pins[bpfm_pkg::FRAMES];
    bit                          dirty[bpfm_pkg::FRAMES];
    int                          free_frames[$];
    int                          lru_frames[$];
    bpfm_pkg::t_result           pending_res[$];

    int  errors;
    int  wdog_cnt;
    bit  idle_en;
    bit  hold_req;
    int  stall_left;

    // Clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor
    function automatic int find_page(logic [bpfm_pkg::PAGE_W-1:0] pid);
        if (pid == bpfm_pkg::NO_PAGE) return -1;
        for (int f = 0; f < bpfm_pkg::FRAMES; f++)
            if (page_of[f] == pid) return f;
        return -1;
    endfunction

    function automatic void lru_drop(int f);
        for (int i = lru_frames.size() - 1; i >= 0; i--)
            if (lru_frames[i] == f) lru_frames.delete(i);
    endfunction

    // Take a frame from the free FIFO, else the LRU head; report a dirty victim
    function automatic int grab_frame(output bit wb,
                                      output logic [bpfm_pkg::PAGE_W-1:0] wbp);
        int f;
        wb  = 1'b0;
        wbp = '0;
        if (free_frames.size() > 0) begin
            f = free_frames[0];
            free_frames.delete(0);
        end else if (lru_frames.size() > 0) begin
            f = lru_frames[0];
            lru_frames.delete(0);
        end else begin
            return -1;
        end
        if (dirty[f] && page_of[f] != bpfm_pkg::NO_PAGE) begin
            wb  = 1'b1;
            wbp = page_of[f];
        end
        return f;
    endfunction

    function automatic void push_res(logic [2:0] st, int f, bit wb,
                                     logic [bpfm_pkg::PAGE_W-1:0] wbp,
                                     bit rd, bit clr, bit dl, bit lst);
        bpfm_pkg::t_result r;
        r.status          = st;
        r.frame           = f[3:0];
        r.write_back      = wb;
        r.write_back_page = wb ? wbp : '0;
        r.read_in         = rd;
        r.clear_frame     = clr;
        r.deallocate      = dl;
        r.last            = lst;
        pending_res.push_back(r);
    endfunction

    function automatic void reset_pool();
        free_frames.delete();
        lru_frames.delete();
        pending_res.delete();
        for (int f = 0; f < bpfm_pkg::FRAMES; f++) begin
            page_of[f] = bpfm_pkg::NO_PAGE;
            pins[f]    = 0;
            dirty[f]   = 1'b0;
            free_frames.push_back(f);
        end
    endfunction

    // Work out the result transactions of one accepted command
    function automatic void predict_cmd(logic [2:0] cmd, logic [bpfm_pkg::PAGE_W-1:0] pid,
                                        bit md);
        int f;
        int tail;
        bit wb;
        logic [bpfm_pkg::PAGE_W-1:0] wbp;
        case (cmd)
            bpfm_pkg::CMD_FETCH, bpfm_pkg::CMD_NEW: begin
                if (pid == bpfm_pkg::NO_PAGE) begin
                    push_res(bpfm_pkg::ST_INVALID, 0, 0, 0, 0, 0, 0, 1);
                    return;
                end
                f = find_page(pid);
                if (f >= 0 && cmd == bpfm_pkg::CMD_NEW) begin
                    push_res(bpfm_pkg::ST_IN_USE, 0, 0, 0, 0, 0, 0, 1);
                end else if (f >= 0) begin
                    if (pins[f] >= PIN_MAX) begin
                        push_res(bpfm_pkg::ST_PIN_SAT, 0, 0, 0, 0, 0, 0, 1);
                    end else begin
                        pins[f]++;
                        lru_drop(f);
                        push_res(bpfm_pkg::ST_OK, f, 0, 0, 0, 0, 0, 1);
                    end
                end else begin
                    f = grab_frame(wb, wbp);
                    if (f < 0) begin
                        push_res(bpfm_pkg::ST_NO_FRAME, 0, 0, 0, 0, 0, 0, 1);
                    end else begin
                        page_of[f] = pid;
                        dirty[f]   = 1'b0;
                        pins[f]    = 1;
                        push_res(bpfm_pkg::ST_OK, f, wb, wbp, cmd == bpfm_pkg::CMD_FETCH,
                                 1, 0, 1);
                    end
                end
            end
            bpfm_pkg::CMD_UNPIN: begin
                f = find_page(pid);
                if (f < 0) begin
                    push_res(bpfm_pkg::ST_NOT_RES, 0, 0, 0, 0, 0, 0, 1);
                    return;
                end
                if (md) dirty[f] = 1'b1;
                if (pins[f] == 0) begin
                    push_res(bpfm_pkg::ST_IN_USE, 0, 0, 0, 0, 0, 0, 1);
                    return;
                end
                pins[f]--;
                if (pins[f] == 0) begin
                    lru_drop(f);
                    lru_frames.push_back(f);
                end
                push_res(bpfm_pkg::ST_OK, f, 0, 0, 0, 0, 0, 1);
            end
            bpfm_pkg::CMD_FLUSH: begin
                f = find_page(pid);
                if (pid == bpfm_pkg::NO_PAGE) begin
                    push_res(bpfm_pkg::ST_INVALID, 0, 0, 0, 0, 0, 0, 1);
                end else if (f < 0) begin
                    push_res(bpfm_pkg::ST_NOT_RES, 0, 0, 0, 0, 0, 0, 1);
                end else begin
                    dirty[f] = 1'b0;
                    push_res(bpfm_pkg::ST_OK, f, 1, pid, 0, 0, 0, 1);
                end
            end
            bpfm_pkg::CMD_DELETE: begin
                f = find_page(pid);
                if (f < 0) begin
                    push_res(bpfm_pkg::ST_OK, 0, 0, 0, 0, 0, 0, 1);
                end else if (pins[f] != 0) begin
                    push_res(bpfm_pkg::ST_IN_USE, 0, 0, 0, 0, 0, 0, 1);
                end else begin
                    page_of[f] = bpfm_pkg::NO_PAGE;
                    dirty[f]   = 1'b0;
                    lru_drop(f);
                    free_frames.push_back(f);
                    push_res(bpfm_pkg::ST_OK, f, 0, 0, 0, 1, 1, 1);
                end
            end
            bpfm_pkg::CMD_FLUSH_ALL: begin
                tail = -1;
                for (int i = 0; i < bpfm_pkg::FRAMES; i++)
                    if (page_of[i] != bpfm_pkg::NO_PAGE) tail = i;
                if (tail < 0) push_res(bpfm_pkg::ST_OK, 0, 0, 0, 0, 0, 0, 1);
                for (int i = 0; i <= tail; i++) begin
                    if (page_of[i] != bpfm_pkg::NO_PAGE) begin
                        dirty[i] = 1'b0;
                        push_res(bpfm_pkg::ST_OK, i, 1, page_of[i], 0, 0, 0, i == tail);
                    end
                end
            end
            default: push_res(bpfm_pkg::ST_INVALID, 0, 0, 0, 0, 0, 0, 1);
        endcase
    endfunction

    // ---------------------------------------------------------------- sender
    // Offer one command, optionally after an idle burst; hold valid across back-to-back items
    task automatic send_cmd(logic [2:0] cmd, logic [bpfm_pkg::PAGE_W-1:0] pid, bit md);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.command    <= cmd;
        cmd_if.page_id    <= pid;
        cmd_if.mark_dirty <= md;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        predict_cmd(cmd, pid, md);
    endtask

    task automatic stop_sending();
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [bpfm_pkg::PAGE_W-1:0] pick_page();
        case ($urandom_range(0, 19))
            0:       return bpfm_pkg::NO_PAGE;
            1:       return 32'h7FFF_FFFF;
            2, 3:    return {1'b0, 31'($urandom())};
            default: return bpfm_pkg::PAGE_W'($urandom_range(0, 23));
        endcase
    endfunction

    function automatic logic [2:0] pick_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 32) return bpfm_pkg::CMD_FETCH;
        if (r < 60) return bpfm_pkg::CMD_UNPIN;
        if (r < 70) return bpfm_pkg::CMD_FLUSH;
        if (r < 80) return bpfm_pkg::CMD_NEW;
        if (r < 92) return bpfm_pkg::CMD_DELETE;
        if (r < 97) return bpfm_pkg::CMD_FLUSH_ALL;
        return 3'($urandom_range(6, 7));
    endfunction

    // ---------------------------------------------------------------- receiver
    // Stall result channel in bursts, or for one long stretch on request
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            res_if.ready <= 1'b0;
        end else if (hold_req) begin
            hold_req   = 1'b0;
            stall_left = LONG_HOLD - 1;
            res_if.ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 9);
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- checker
    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        bpfm_pkg::t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_res.size() == 0) begin
                $error("result transaction with nothing expected");
                errors++;
            end else begin
                want = pending_res[0];
                pending_res.delete(0);
                check_field("status", want.status, res_if.status);
                check_field("frame", want.frame, res_if.frame);
                check_field("write_back", want.write_back, res_if.write_back);
                check_field("write_back_page", want.write_back_page,
                            res_if.write_back_page);
                check_field("read_in", want.read_in, res_if.read_in);
                check_field("clear_frame", want.clear_frame, res_if.clear_frame);
                check_field("deallocate", want.deallocate, res_if.deallocate);
                check_field("last", want.last, res_if.last);
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
            wdog_cnt = 0;
        end else begin
            wdog_cnt = wdog_cnt + 1;
        end
        if (wdog_cnt >= WDOG_MAX) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests
    task automatic test_directed();
        send_cmd(bpfm_pkg::CMD_FLUSH_ALL, 0, 0);                // nothing resident
        send_cmd(bpfm_pkg::CMD_FETCH, bpfm_pkg::NO_PAGE, 0);
        send_cmd(bpfm_pkg::CMD_FLUSH, bpfm_pkg::NO_PAGE, 0);
        send_cmd(bpfm_pkg::CMD_NEW, bpfm_pkg::NO_PAGE, 0);
        send_cmd(bpfm_pkg::CMD_UNPIN, bpfm_pkg::NO_PAGE, 1);
        send_cmd(bpfm_pkg::CMD_DELETE, bpfm_pkg::NO_PAGE, 0);
        send_cmd(3'd6, 32'h7FFF_FFFF, 1);
        send_cmd(3'd7, 0, 0);
        send_cmd(bpfm_pkg::CMD_FETCH, 32'h7FFF_FFFF, 0);
        send_cmd(bpfm_pkg::CMD_UNPIN, 32'h7FFF_FFFF, 1);
        send_cmd(bpfm_pkg::CMD_UNPIN, 32'h7FFF_FFFF, 1);        // already unpinned
        send_cmd(bpfm_pkg::CMD_FLUSH, 32'h7FFF_FFFF, 0);
        send_cmd(bpfm_pkg::CMD_FLUSH, 32'h5555_AAAA, 0);        // not resident
        send_cmd(bpfm_pkg::CMD_NEW, 100, 0);
        send_cmd(bpfm_pkg::CMD_NEW, 100, 0);                    // already resident
        send_cmd(bpfm_pkg::CMD_DELETE, 100, 0);                 // still pinned
        send_cmd(bpfm_pkg::CMD_UNPIN, 100, 0);
        send_cmd(bpfm_pkg::CMD_DELETE, 100, 0);
        send_cmd(bpfm_pkg::CMD_DELETE, 100, 0);                 // gone already
        // Pin every frame, then ask for one more
        for (int p = 200; p < 200 + bpfm_pkg::FRAMES; p++)
            send_cmd(bpfm_pkg::CMD_FETCH, p, 0);
        send_cmd(bpfm_pkg::CMD_FETCH, 300, 0);
        send_cmd(bpfm_pkg::CMD_NEW, 301, 0);
        send_cmd(bpfm_pkg::CMD_FLUSH_ALL, 0, 0);
        // Release dirty, then force dirty victims out of the LRU
        for (int p = 200; p < 200 + bpfm_pkg::FRAMES; p++)
            send_cmd(bpfm_pkg::CMD_UNPIN, p, 1);
        send_cmd(bpfm_pkg::CMD_FETCH, 400, 0);
        send_cmd(bpfm_pkg::CMD_NEW, 401, 0);
        send_cmd(bpfm_pkg::CMD_UNPIN, 400, 0);
        send_cmd(bpfm_pkg::CMD_UNPIN, 401, 1);
    endtask

    // Stack several pins on one page, then release them all
    task automatic test_pin_stack();
        for (int i = 0; i < PIN_DEPTH; i++) send_cmd(bpfm_pkg::CMD_FETCH, 32'h0000_0055, 0);
        for (int i = 0; i < PIN_DEPTH; i++) send_cmd(bpfm_pkg::CMD_UNPIN, 32'h0000_0055, 0);
        send_cmd(bpfm_pkg::CMD_UNPIN, 32'h0000_0055, 0);        // no pin left
    endtask

    task automatic test_random(int n);
        logic [2:0]                  cmd;
        logic [bpfm_pkg::PAGE_W-1:0] pid;
        for (int i = 0; i < n; i++) begin
            cmd = pick_cmd();
            pid = pick_page();
            send_cmd(cmd, pid, 1'($urandom_range(0, 1)));
            // Follow a fetch with its unpin most of the time
            if (cmd == bpfm_pkg::CMD_FETCH && $urandom_range(0, 2) != 0)
                send_cmd(bpfm_pkg::CMD_UNPIN, pid, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int i = 0; i < 8; i++) send_cmd(bpfm_pkg::CMD_FLUSH_ALL, 0, 0);
    endtask

    initial begin
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        cmd_if.valid      = 1'b0;
        cmd_if.command    = bpfm_pkg::CMD_FETCH;
        cmd_if.page_id    = '0;
        cmd_if.mark_dirty = 1'b0;
        res_if.ready      = 1'b0;
        errors            = 0;
        wdog_cnt          = 0;
        idle_en           = 1'b0;
        hold_req          = 1'b0;
        stall_left        = 0;
        reset_pool();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_en = 1'b1;
        test_directed();
        idle_en = 1'b0;
        test_pin_stack();
        idle_en = 1'b1;
        test_random(160);
        test_backpressure();
        test_random(160);
        idle_en = 1'b0;
        test_random(50);
        stop_sending();

        // Drain outstanding results
        while (pending_res.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/bpfm_pkg.sv
hdl/bpfm_if.sv
hdl/bpfm_dp.sv
hdl/bpfm_ctrl.sv
hdl/buffer_pool_frame_manager.sv
test/tb_top.sv
